### rtl/core/lpnm_pkg.sv
// lpnm_pkg: shared types and constants of the local peak detector
// used by the front, back and top level modules; no dependencies
package lpnm_pkg;

  localparam int PIX_W      = 32;  // width of the pixel port
  localparam int IDX_W      = 10;  // width of the row and column result fields
  localparam int CFG_W      = 11;  // width of a configuration register
  localparam int CFG_IDX_W  = 8;   // width of the configuration index
  localparam int CNT_MAX_W  = 13;  // holds a count up to the largest matrix size
  localparam int CNT_RESET  = 10;  // row and column count after reset
  localparam int MID_DEPTH  = 4;   // queue between front and back
  localparam int OUT_DEPTH  = 8;   // result queue

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  // decision bits, in emission order
  localparam int DEC_UPLEFT = 0;  // centre one row up, one column left
  localparam int DEC_UP     = 1;  // centre one row up, current column
  localparam int DEC_LEFT   = 2;  // centre on current row, one column left
  localparam int DEC_HERE   = 3;  // centre on the current position

  typedef struct packed {
    logic [3:0] dec;
    logic       r_ge1;
    logic       r_ge2;
    logic       c_ge1;
    logic       c_ge2;
  } dec_ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic             is_peak;
    logic             last_of_matrix;
  } res_t;

  // zero counts as one, anything above the maximum saturates
  function automatic logic [CNT_MAX_W-1:0] clamp_count(
    input logic [CFG_W-1:0]     v,
    input logic [CNT_MAX_W-1:0] maxv
  );
    logic [CNT_MAX_W-1:0] ve;
    ve = CNT_MAX_W'(v);
    if (ve == '0) begin
      clamp_count = CNT_MAX_W'(1);
    end else if (ve > maxv) begin
      clamp_count = maxv;
    end else begin
      clamp_count = ve;
    end
  endfunction

endpackage

### rtl/core/lpnm_fifo.sv
// lpnm_fifo: small register queue with occupancy count
// depends on nothing; DEPTH must be a power of two of at least 2
module lpnm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             full;
  logic             wr_ok, rd_ok;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign count   = cnt_r;
  assign rd_data = mem_r[rd_ptr_r];
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(wr_ok);
    rd_ptr_nxt = rd_ptr_r + AW'(rd_ok);
    cnt_nxt    = cnt_r + CW'(wr_ok) - CW'(rd_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### rtl/core/lpnm_front.sv
// lpnm_front: configuration registers, raster position, line buffer and 3x3 window
// depends on lpnm_pkg; feeds one window snapshot per item that decides something
module lpnm_front import lpnm_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_valid,
  input  logic [CFG_IDX_W-1:0]                   cfg_index,
  input  logic [CFG_W-1:0]                       cfg_wdata,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic [PIX_W-1:0]                       in_pixel_value,
  output logic                                   mid_push,
  input  logic                                   mid_full,
  output logic [9*DATA_WIDTH-1:0]                mid_win,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] mid_row,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] mid_col,
  output dec_ctl_t                               mid_ctl
);

  localparam int DW       = DATA_WIDTH;
  localparam int COL_AW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CCNT_W   = $clog2(MAX_COLS + 1);
  localparam int RCNT_W   = $clog2(MAX_ROWS + 1);
  localparam int CC1      = CCNT_W + 1;
  localparam int RC1      = RCNT_W + 1;
  localparam int RST_COLS = (MAX_COLS < CNT_RESET) ? MAX_COLS : CNT_RESET;
  localparam int RST_ROWS = (MAX_ROWS < CNT_RESET) ? MAX_ROWS : CNT_RESET;

  logic [CCNT_W-1:0] col_cnt_r;
  logic [RCNT_W-1:0] row_cnt_r;
  logic [COL_AW-1:0] col_pos_r, col_pos_nxt;
  logic [ROW_AW-1:0] row_pos_r, row_pos_nxt;
  logic              cfg_row_wr, cfg_col_wr;
  logic              accept, last_col, last_row;
  dec_ctl_t          ctl_nxt;

  // stage 1: item waits here for its line buffer read
  logic              s1_vld_r;
  logic [DW-1:0]     s1_v_r;
  logic [ROW_AW-1:0] s1_row_r;
  logic [COL_AW-1:0] s1_col_r;
  dec_ctl_t          s1_ctl_r;
  logic              s1_adv;

  // line buffer entry holds {row r-2, row r-1} of one column
  logic [2*DW-1:0]   lbuf [MAX_COLS];
  logic [2*DW-1:0]   rd_r;
  logic              byp_vld_r;
  logic [2*DW-1:0]   byp_r;
  logic [2*DW-1:0]   col_eff;
  logic [2*DW-1:0]   wr_data;

  logic [DW-1:0]     win_r   [9];
  logic [DW-1:0]     win_nxt [9];

  assign cfg_row_wr = cfg_valid && (cfg_index == REG_ROW_COUNT);
  assign cfg_col_wr = cfg_valid && (cfg_index == REG_COL_COUNT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= CCNT_W'(RST_COLS);
      row_cnt_r <= RCNT_W'(RST_ROWS);
    end else begin
      if (cfg_row_wr) begin
        row_cnt_r <= RCNT_W'(clamp_count(cfg_wdata, CNT_MAX_W'(MAX_ROWS)));
      end
      if (cfg_col_wr) begin
        col_cnt_r <= CCNT_W'(clamp_count(cfg_wdata, CNT_MAX_W'(MAX_COLS)));
      end
    end
  end

  assign s1_adv  = s1_vld_r && !mid_full;
  assign in_full = s1_vld_r && mid_full;
  assign accept  = in_push && !in_full;

  assign last_col = (CC1'(col_pos_r) + CC1'(1)) >= CC1'(col_cnt_r);
  assign last_row = (RC1'(row_pos_r) + RC1'(1)) >= RC1'(row_cnt_r);

  always_comb begin
    ctl_nxt.r_ge1 = (row_pos_r != '0);
    ctl_nxt.r_ge2 = (row_pos_r > ROW_AW'(1));
    ctl_nxt.c_ge1 = (col_pos_r != '0);
    ctl_nxt.c_ge2 = (col_pos_r > COL_AW'(1));
    ctl_nxt.dec[DEC_UPLEFT] = ctl_nxt.r_ge1 && ctl_nxt.c_ge1;
    ctl_nxt.dec[DEC_UP]     = ctl_nxt.r_ge1 && last_col;
    ctl_nxt.dec[DEC_LEFT]   = last_row && ctl_nxt.c_ge1;
    ctl_nxt.dec[DEC_HERE]   = last_row && last_col;
  end

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (cfg_row_wr || cfg_col_wr) begin
      col_pos_nxt = '0;
      row_pos_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_pos_nxt = '0;
        row_pos_nxt = last_row ? '0 : row_pos_r + ROW_AW'(1);
      end else begin
        col_pos_nxt = col_pos_r + COL_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      s1_vld_r  <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      if (accept) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v_r   <= in_pixel_value[DW-1:0];
      s1_row_r <= row_pos_r;
      s1_col_r <= col_pos_r;
      s1_ctl_r <= ctl_nxt;
    end
  end

  // a write leaving stage 1 on the same edge as a read of that column is forwarded
  assign col_eff = byp_vld_r ? byp_r : rd_r;
  assign wr_data = {col_eff[DW-1:0], s1_v_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r      <= lbuf[col_pos_r];
      byp_vld_r <= s1_adv && (s1_col_r == col_pos_r);
      byp_r     <= wr_data;
    end
    if (s1_adv) begin
      lbuf[s1_col_r] <= wr_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i*3+0] = win_r[i*3+1];
      win_nxt[i*3+1] = win_r[i*3+2];
    end
    win_nxt[2] = col_eff[2*DW-1:DW];
    win_nxt[5] = col_eff[DW-1:0];
    win_nxt[8] = s1_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 9; n++) begin
        win_r[n] <= '0;
      end
    end else if (s1_adv) begin
      for (int n = 0; n < 9; n++) begin
        win_r[n] <= win_nxt[n];
      end
    end
  end

  always_comb begin
    for (int n = 0; n < 9; n++) begin
      mid_win[n*DW +: DW] = win_nxt[n];
    end
  end

  assign mid_push = s1_adv && (s1_ctl_r.dec != '0);
  assign mid_row  = s1_row_r;
  assign mid_col  = s1_col_r;
  assign mid_ctl  = s1_ctl_r;

endmodule

### rtl/core/lpnm_back.sv
// lpnm_back: works through the decisions of each window snapshot, one per cycle while the result
// queue has room; depends on lpnm_pkg and lpnm_fifo; sum and product stages feed the result queue
module lpnm_back import lpnm_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    mid_empty,
  output logic                    mid_pop,
  input  logic [9*DATA_WIDTH-1:0] mid_win,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] mid_row,
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] mid_col,
  input  dec_ctl_t                mid_ctl,
  input  logic                    out_pop,
  output logic                    out_empty,
  output res_t                    out_res
);

  localparam int DW     = DATA_WIDTH;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int OCW    = $clog2(OUT_DEPTH + 1);

  // snapshot being worked on
  logic                 cur_vld_r;
  logic [3:0]           cur_dec_r;
  logic signed [DW-1:0] cur_win_r [9];
  logic [ROW_AW-1:0]    cur_row_r;
  logic [COL_AW-1:0]    cur_col_r;
  dec_ctl_t             cur_ctl_r;

  logic [3:0]           sel_oh, dec_left;
  logic                 here_row, here_col;
  logic                 room, issue, load;
  logic [OCW-1:0]       out_cnt;

  logic                 row_ok [3];
  logic                 col_ok [3];
  logic signed [DW-1:0] cell_m [9];
  logic signed [DW-1:0] centre;
  logic [3:0]           cnt_nxt;

  // stage 1: pair sums
  logic                 p1_vld_r;
  logic signed [DW:0]   p1_sum_r [5];
  logic signed [DW:0]   p1_sum_nxt [5];
  logic [3:0]           p1_cnt_r;
  logic signed [DW-1:0] p1_ctr_r;
  logic [ROW_AW-1:0]    p1_row_r;
  logic [COL_AW-1:0]    p1_col_r;
  logic                 p1_last_r;

  // stage 2: neighbour sum and centre times count
  logic                 p2_vld_r;
  logic signed [DW+3:0] p2_sum_r;
  logic signed [DW+4:0] p2_prod_r;
  logic [ROW_AW-1:0]    p2_row_r;
  logic [COL_AW-1:0]    p2_col_r;
  logic                 p2_last_r;

  res_t                 res_in;

  assign sel_oh   = cur_dec_r & (~cur_dec_r + 4'd1);
  assign dec_left = cur_dec_r & ~sel_oh;
  assign here_col = sel_oh[DEC_UP] | sel_oh[DEC_HERE];
  assign here_row = sel_oh[DEC_LEFT] | sel_oh[DEC_HERE];

  // results in flight are counted against the free space of the result queue
  assign room  = ((OCW+1)'(out_cnt) + (OCW+1)'(p1_vld_r) + (OCW+1)'(p2_vld_r))
                 < (OCW+1)'(OUT_DEPTH);
  assign issue = cur_vld_r && room;
  assign load  = !mid_empty && (!cur_vld_r || (issue && (dec_left == '0)));
  assign mid_pop = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
    end else if (load) begin
      cur_vld_r <= 1'b1;
    end else if (issue && (dec_left == '0)) begin
      cur_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int n = 0; n < 9; n++) begin
        cur_win_r[n] <= mid_win[n*DW +: DW];
      end
      cur_row_r <= mid_row;
      cur_col_r <= mid_col;
      cur_ctl_r <= mid_ctl;
      cur_dec_r <= mid_ctl.dec;
    end else if (issue) begin
      cur_dec_r <= dec_left;
    end
  end

  // pick the in-bounds neighbours of the selected centre
  always_comb begin
    row_ok[0] = cur_ctl_r.r_ge2;
    row_ok[1] = cur_ctl_r.r_ge1;
    row_ok[2] = 1'b1;
    col_ok[0] = cur_ctl_r.c_ge2;
    col_ok[1] = cur_ctl_r.c_ge1;
    col_ok[2] = 1'b1;
    cnt_nxt   = '0;
    centre    = cur_win_r[{1'b0, here_row} * 3 + 4 + {1'b0, here_col}];
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        logic near_cell, is_ctr, take;
        near_cell = ((i != 0) || !here_row) && ((j != 0) || !here_col);
        is_ctr    = (i == 1 + int'(here_row)) && (j == 1 + int'(here_col));
        take      = near_cell && !is_ctr && row_ok[i] && col_ok[j];
        cell_m[i*3+j] = take ? cur_win_r[i*3+j] : '0;
        cnt_nxt = cnt_nxt + 4'(take);
      end
    end
    p1_sum_nxt[0] = (DW+1)'(cell_m[0]) + (DW+1)'(cell_m[1]);
    p1_sum_nxt[1] = (DW+1)'(cell_m[2]) + (DW+1)'(cell_m[3]);
    p1_sum_nxt[2] = (DW+1)'(cell_m[4]) + (DW+1)'(cell_m[5]);
    p1_sum_nxt[3] = (DW+1)'(cell_m[6]) + (DW+1)'(cell_m[7]);
    p1_sum_nxt[4] = (DW+1)'(cell_m[8]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= issue;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      for (int n = 0; n < 5; n++) begin
        p1_sum_r[n] <= p1_sum_nxt[n];
      end
      p1_cnt_r  <= cnt_nxt;
      p1_ctr_r  <= centre;
      p1_row_r  <= here_row ? cur_row_r : cur_row_r - ROW_AW'(1);
      p1_col_r  <= here_col ? cur_col_r : cur_col_r - COL_AW'(1);
      p1_last_r <= sel_oh[DEC_HERE];
    end
    if (p1_vld_r) begin
      p2_sum_r  <= (DW+4)'(p1_sum_r[0]) + (DW+4)'(p1_sum_r[1]) + (DW+4)'(p1_sum_r[2])
                   + (DW+4)'(p1_sum_r[3]) + (DW+4)'(p1_sum_r[4]);
      p2_prod_r <= (DW+5)'(p1_ctr_r) * $signed({1'b0, p1_cnt_r});
      p2_row_r  <= p1_row_r;
      p2_col_r  <= p1_col_r;
      p2_last_r <= p1_last_r;
    end
  end

  // no neighbours gives 0 < 0, so a lone cell is never a peak
  always_comb begin
    res_in.row_index      = IDX_W'(p2_row_r);
    res_in.col_index      = IDX_W'(p2_col_r);
    res_in.is_peak        = (DW+5)'(p2_sum_r) < p2_prod_r;
    res_in.last_of_matrix = p2_last_r;
  end

  // room never lets the queue overflow
  lpnm_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (p2_vld_r),
    .wr_data (res_in),
    .rd_en   (out_pop),
    .rd_data (out_res),
    .empty   (out_empty),
    .count   (out_cnt)
  );

endmodule

### rtl/core/local_peak_over_neighbor_mean_unit.sv
// Local peak detector over a raster stream of signed values. Set row_count (index 0) and
// col_count (index 1) while the block is idle; any such write restarts the matrix at (0,0).
// Each item is one value; results come out in decision order, one per position, with its row,
// column, peak flag and a last flag on the final position. The front takes one item per cycle
// while the middle queue has room (one line buffer read and one write per item, forwarded
// when that column is read as its write leaves); the back decides one position per cycle
// while the result queue has room, so intake runs at one item per cycle except at row ends
// (two results) and on the last row (two per item, four on the final item), where it follows
// the result rate. The line buffer needs no clearing pass.
// Depends on lpnm_pkg, lpnm_fifo, lpnm_front and lpnm_back.
module local_peak_over_neighbor_mean_unit import lpnm_pkg::*; #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [PIX_W-1:0]     in_pixel_value,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [IDX_W-1:0]     out_row_index,
  output logic [IDX_W-1:0]     out_col_index,
  output logic                 out_is_peak,
  output logic                 out_last_of_matrix
);

  localparam int DW     = DATA_WIDTH;
  localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int MID_W  = 9*DW + ROW_AW + COL_AW + $bits(dec_ctl_t);
  localparam int MCW    = $clog2(MID_DEPTH + 1);

  logic              mid_push, mid_pop, mid_full, mid_empty;
  logic [MCW-1:0]    mid_cnt;
  logic [9*DW-1:0]   f_win, b_win;
  logic [ROW_AW-1:0] f_row, b_row;
  logic [COL_AW-1:0] f_col, b_col;
  dec_ctl_t          f_ctl, b_ctl;
  logic [MID_W-1:0]  mid_wr, mid_rd;
  res_t              res;

  assign cfg_ready = 1'b1;

  lpnm_front #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_pixel_value (in_pixel_value),
    .mid_push       (mid_push),
    .mid_full       (mid_full),
    .mid_win        (f_win),
    .mid_row        (f_row),
    .mid_col        (f_col),
    .mid_ctl        (f_ctl)
  );

  assign mid_wr = {f_win, f_row, f_col, f_ctl};
  assign {b_win, b_row, b_col, b_ctl} = mid_rd;
  assign mid_full = (mid_cnt == MCW'(MID_DEPTH));

  lpnm_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (mid_push),
    .wr_data (mid_wr),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty),
    .count   (mid_cnt)
  );

  lpnm_back #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .mid_win   (b_win),
    .mid_row   (b_row),
    .mid_col   (b_col),
    .mid_ctl   (b_ctl),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_row_index      = res.row_index;
  assign out_col_index      = res.col_index;
  assign out_is_peak        = res.is_peak;
  assign out_last_of_matrix = res.last_of_matrix;

endmodule

### test/testbench.sv
// testbench for local_peak_over_neighbor_mean_unit: streams matrices in raster order, predicts
// each neighbour-mean peak decision and checks the result queue item by item
// depends on lpnm_pkg and the rtl of the unit
`timescale 1ns / 1ps

module testbench;
  import lpnm_pkg::*;

  localparam int LINE_LEN      = 1024;
  localparam int ROW_LIMIT     = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES  = 400000;
  localparam int RANDOM_ITEMS  = 190;
  localparam int PARTIAL_LEN   = 24;

  localparam logic [PIX_W-1:0] PIX_MIN = {1'b1, {(PIX_W-1){1'b0}}};
  localparam logic [PIX_W-1:0] PIX_MAX = {1'b0, {(PIX_W-1){1'b1}}};
  localparam logic [PIX_W-1:0] EXTREMES [4] = '{PIX_MIN, PIX_MAX, '0, '1};

  typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;
  typedef enum {FILL_WIDE, FILL_NEAR, FILL_MIXED} fill_t;

  logic                 clk;
  logic                 rst_n          = 1'b0;
  logic                 cfg_valid      = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_W-1:0]     cfg_wdata      = '0;
  logic                 in_push        = 1'b0;
  logic                 in_full;
  logic [PIX_W-1:0]     in_pixel_value = '0;
  logic                 out_empty;
  logic                 out_pop        = 1'b0;
  logic [IDX_W-1:0]     out_row_index;
  logic [IDX_W-1:0]     out_col_index;
  logic                 out_is_peak;
  logic                 out_last_of_matrix;

  // predictor state
  longint   line_older  [LINE_LEN];
  longint   line_recent [LINE_LEN];
  longint   win [3][3];
  int       rows_used = CNT_RESET;
  int       cols_used = CNT_RESET;
  int       cur_row   = 0;
  int       cur_col   = 0;
  res_t     expected_decisions [$];

  int       fail_count  = 0;
  int       pixels_sent = 0;
  int       gap_max     = 0;
  int       burst_left  = 0;
  int       hold_left   = 0;
  int       rx_tick     = 0;
  int       cycle_count = 0;
  rx_mode_t rx_mode     = RX_STEADY;

  local_peak_over_neighbor_mean_unit #(
    .MAX_COLS  (LINE_LEN),
    .MAX_ROWS  (ROW_LIMIT),
    .DATA_WIDTH(PIX_W)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_pixel_value    (in_pixel_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_row_index     (out_row_index),
    .out_col_index     (out_col_index),
    .out_is_peak       (out_is_peak),
    .out_last_of_matrix(out_last_of_matrix)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("local_peak_over_neighbor_mean_unit: mismatch");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int fit_count(input logic [CFG_W-1:0] value, input int maxv);
    if (value == '0) return 1;
    if (int'(value) > maxv) return maxv;
    return int'(value);
  endfunction

  // strict test of centre against the mean of in-bounds neighbours, kept exact as
  // sum < centre * count; the window holds rows r-2..r and columns c-2..c
  function automatic bit is_local_peak(input int rr, input int cc, input int r, input int c);
    longint total;
    longint weight;
    longint centre;
    int     a, b, da, db;
    total  = 0;
    weight = 0;
    centre = win[rr-r+2][cc-c+2];
    for (da = -1; da <= 1; da++) begin
      for (db = -1; db <= 1; db++) begin
        a = rr + da;
        b = cc + db;
        if ((da != 0 || db != 0) && a >= 0 && b >= 0 && a < rows_used && b < cols_used &&
            a - r + 2 >= 0 && a - r + 2 <= 2 && b - c + 2 >= 0 && b - c + 2 <= 2) begin
          total  += win[a-r+2][b-c+2];
          weight++;
        end
      end
    end
    return (weight != 0) && (total < centre * weight);
  endfunction

  task automatic note_decision(input int rr, input int cc, input int r, input int c);
    res_t d;
    d.row_index      = IDX_W'(rr);
    d.col_index      = IDX_W'(cc);
    d.is_peak        = is_local_peak(rr, cc, r, c);
    d.last_of_matrix = (rr == rows_used - 1) && (cc == cols_used - 1);
    expected_decisions.push_back(d);
  endtask

  task automatic predict_pixel(input logic [PIX_W-1:0] raw);
    longint val, up2, up1;
    bit     end_col, end_row;
    int     r, c, i;
    val     = longint'($signed(raw));
    r       = cur_row;
    c       = cur_col;
    end_col = (c + 1 >= cols_used);
    end_row = (r + 1 >= rows_used);
    up2 = line_older[c];
    up1 = line_recent[c];
    line_older[c]  = up1;
    line_recent[c] = val;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = val;
    if (r >= 1 && c >= 1) note_decision(r - 1, c - 1, r, c);
    if (r >= 1 && end_col) note_decision(r - 1, c, r, c);
    if (end_row && c >= 1) note_decision(r, c - 1, r, c);
    if (end_row && end_col) note_decision(r, c, r, c);
    if (end_col) begin
      cur_col = 0;
      cur_row = end_row ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
    end
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    if (idx == REG_ROW_COUNT) begin
      rows_used = fit_count(value, ROW_LIMIT);
    end else if (idx == REG_COL_COUNT) begin
      cols_used = fit_count(value, LINE_LEN);
    end else begin
      return;
    end
    cur_row = 0;
    cur_col = 0;
  endtask

  // ---------------------------------------------------------------- result side

  task automatic compare_field(input string name, input logic [IDX_W-1:0] want,
                               input logic [IDX_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_decision();
    res_t want;
    if (expected_decisions.size() == 0) begin
      $error("decision with none expected: row %0d col %0d", out_row_index, out_col_index);
      fail_count++;
    end else begin
      want = expected_decisions.pop_front();
      compare_field("row_index", want.row_index, out_row_index);
      compare_field("col_index", want.col_index, out_col_index);
      compare_field("is_peak", IDX_W'(want.is_peak), IDX_W'(out_is_peak));
      compare_field("last_of_matrix", IDX_W'(want.last_of_matrix), IDX_W'(out_last_of_matrix));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) check_decision();
    rx_tick <= rx_tick + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_pop   <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_pop <= 1'b1;
        RX_RANDOM: out_pop <= ($urandom_range(0, 3) != 0);
        default:   out_pop <= (rx_tick % 7) < 3;
      endcase
    end
  end

  // ---------------------------------------------------------------- input side

  task automatic send_pixel(input logic [PIX_W-1:0] value);
    int gap;
    in_push        <= 1'b1;
    in_pixel_value <= value;
    do @(posedge clk); while (in_full);
    predict_pixel(value);
    pixels_sent++;
    if (gap_max != 0) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, gap_max);
        burst_left = $urandom_range(1, 16);
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input fill_t fill);
    int near;
    near = int'($urandom_range(0, 6)) - 3;
    if ($urandom_range(0, 7) == 0) return EXTREMES[$urandom_range(0, 3)];
    case (fill)
      FILL_NEAR:  return PIX_W'(near);
      FILL_MIXED: return $urandom_range(0, 1) ? PIX_W'(near) : PIX_W'($urandom);
      default:    return PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_IDX_W-1:0] pick_bad_index();
    return CFG_IDX_W'($urandom_range(int'(REG_COL_COUNT) + 1, (1 << CFG_IDX_W) - 1));
  endfunction

  task automatic send_matrix(input int n, input fill_t fill);
    repeat (n) send_pixel(pick_pixel(fill));
  endtask

  // wait for every expected decision, then let items that decide nothing run through
  task automatic drain();
    in_push <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    drain();
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_size();
    rx_mode <= RX_STEADY;
    gap_max = 0;
    send_matrix(CNT_RESET * CNT_RESET, FILL_MIXED);
  endtask

  task automatic test_lone_cell();
    // row count of zero counts as one; a 1x1 matrix has no neighbours
    set_size('0, CFG_W'(1));
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
  endtask

  task automatic test_extreme_values();
    set_size(CFG_W'(3), CFG_W'(3));
    send_pixel(PIX_MIN);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MIN);
    send_pixel(PIX_MAX);
    send_pixel(PIX_MAX);
    send_pixel('0);
    send_pixel('1);
    send_pixel(PIX_W'(1));
    send_pixel(PIX_MIN);
  endtask

  task automatic test_ties();
    // equal values are never strictly above their mean
    set_size(CFG_W'(2), CFG_W'(2));
    repeat (4) send_pixel(PIX_MAX);
  endtask

  task automatic test_thin_shapes();
    set_size(CFG_W'(1), CFG_W'(2));
    send_pixel(PIX_W'(5));
    send_pixel('1);
    set_size(CFG_W'(2), CFG_W'(1));
    send_pixel(PIX_MIN);
    send_pixel('0);
  endtask

  task automatic test_restart_and_bad_index();
    set_size(CFG_W'(2), CFG_W'(3));
    send_matrix(4, FILL_NEAR);
    drain();
    // unknown register index leaves the position alone
    write_reg(pick_bad_index(), CFG_W'($urandom));
    send_matrix(2, FILL_NEAR);
    send_matrix(2, FILL_WIDE);
    drain();
    // valid write restarts mid-matrix
    write_reg(REG_COL_COUNT, CFG_W'(3));
    send_matrix(6, FILL_MIXED);
  endtask

  task automatic test_largest_sizes();
    // saturated counts, checked on the opening stretch of a thin matrix
    rx_mode <= RX_STEADY;
    gap_max = 0;
    set_size('1, CFG_W'(1));
    send_matrix(PARTIAL_LEN, FILL_MIXED);
    set_size(CFG_W'(1), CFG_W'(1500));
    send_matrix(PARTIAL_LEN, FILL_MIXED);
  endtask

  task automatic test_backpressure();
    set_size(CFG_W'(6), CFG_W'(10));
    rx_mode   <= RX_STEADY;
    hold_left <= 400;
    gap_max = 0;
    send_matrix(60, FILL_MIXED);
  endtask

  task automatic test_random_matrices();
    int    start, rows, cols, total, cut;
    fill_t fill;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      rows  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 6);
      cols  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 8);
      total = rows * cols;
      fill  = fill_t'($urandom_range(0, 2));
      set_size(CFG_W'(rows), CFG_W'(cols));
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (total > 1 && $urandom_range(0, 7) == 0) begin
        // broken matrix: stop part way, then either resume past a bad write or abandon
        cut = $urandom_range(1, total - 1);
        send_matrix(cut, fill);
        drain();
        if ($urandom_range(0, 1)) begin
          write_reg(pick_bad_index(), CFG_W'($urandom));
          send_matrix(total - cut, fill);
        end
      end else begin
        send_matrix(total, fill);
        if ($urandom_range(0, 3) == 0) send_matrix(total, fill);
      end
    end
    gap_max = 0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_size();
    test_lone_cell();
    test_extreme_values();
    test_ties();
    test_thin_shapes();
    test_restart_and_bad_index();
    test_largest_sizes();
    test_backpressure();
    test_random_matrices();
    drain();
    if (fail_count == 0) begin
      $display("local_peak_over_neighbor_mean_unit: match");
    end else begin
      $display("local_peak_over_neighbor_mean_unit: mismatch");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lpnm_pkg.sv
rtl/core/lpnm_fifo.sv
rtl/core/lpnm_front.sv
rtl/core/lpnm_back.sv
rtl/core/local_peak_over_neighbor_mean_unit.sv
test/testbench.sv
